// ===== hdl/masked_logit_log_probability_defines.svh =====
// Assertion macros used by the file that checks this block.
`ifndef MASKED_LOGIT_LOG_PROBABILITY_DEFINES_SVH
`define MASKED_LOGIT_LOG_PROBABILITY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MLLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MLLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mllp_pkg.sv =====
package mllp_pkg;

  // Store depth bounds and fixed job field widths
  localparam int MAX_ALTS_DEF = 64;
  localparam int JOB_CNT_W    = 9;
  localparam int JOB_IDX_W    = 8;
  localparam int JOB_Q_DEPTH  = 2;

  // Fixed-point constants
  localparam logic [31:0] TEN_Q16_M1 = 32'd655359;
  localparam logic [16:0] RECIP10    = 17'd52429;
  localparam int          RECIP10_SH = 19;
  localparam logic [30:0] ONE_Q30    = 31'd1073741824;
  localparam logic [30:0] HALF_Q30   = 31'd536870912;
  localparam logic [30:0] LN2_Q30    = 31'd744261118;
  localparam int          DIV_NUM_W  = 61;
  localparam int          LN_BITS    = 16;

  // exp(-2^j) in Q30 for j = -16 .. 4
  localparam int EXP_TAB_N = 21;
  localparam logic [30:0] EXP_TAB [EXP_TAB_N] = '{
    31'd1073725440, 31'd1073709056, 31'd1073676290, 31'd1073610760, 31'd1073479712,
    31'd1073217664, 31'd1072693760, 31'd1071646719, 31'd1069555701, 31'd1065385899,
    31'd1057095000, 31'd1040706261, 31'd1008687096, 31'd947573834,  31'd836230973,
    31'd651257337,  31'd395007542,  31'd145315154,  31'd19666268,   31'd360200,
    31'd121
  };

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_UNAVAIL = 2'd2
  } status_t;

  // One classified choice set handed from front to back
  typedef struct packed {
    logic                 run;
    status_t              status;
    logic                 log_mode;
    logic signed [31:0]   max_u;
    logic [JOB_CNT_W-1:0] count;
    logic [JOB_IDX_W-1:0] slot;
  } job_t;

endpackage

// ===== hdl/mllp_in_if.sv =====
interface mllp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         alt_key;
  logic signed [31:0] utility;
  logic               available;
  logic [7:0]         chosen_key;
  logic               last_alt;

  modport source (output valid, alt_key, utility, available, chosen_key, last_alt,
                  input ready);
  modport sink (input valid, alt_key, utility, available, chosen_key, last_alt,
                output ready);
endinterface

// ===== hdl/mllp_out_if.sv =====
interface mllp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ===== hdl/mllp_div.sv =====
module mllp_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 38
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CW'(1));
      if (start && !run_r) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NUM_W);
        rem_r <= '0;
        num_r <= num;
        den_r <= den;
        quo_r <= '0;
      end else if (run_r) begin
        rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        num_r <= num_r << 1;
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== hdl/mllp_job_fifo.sv =====
module mllp_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mllp_pkg::job_t push_data,
  input  logic          pop,
  output mllp_pkg::job_t pop_data,
  output logic          empty
);
  import mllp_pkg::*;

  localparam int PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

  job_t             slot_r [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             full;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(JOB_Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign pop_data = slot_r[rp_r];
endmodule

// ===== hdl/mllp_front.sv =====
module mllp_front #(
  parameter int MAX_ALTS = mllp_pkg::MAX_ALTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mllp_in_if.sink                     in_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        set_done,
  output logic                        mem_we,
  output logic [$clog2(MAX_ALTS)-1:0] mem_waddr,
  output logic signed [31:0]          mem_wdata,
  output logic                        job_push,
  output mllp_pkg::job_t              job
);
  import mllp_pkg::*;

  localparam int IDX_W = $clog2(MAX_ALTS);
  localparam int CNT_W = $clog2(MAX_ALTS + 1);

  logic               log_mode_r;
  logic               busy_r;
  logic               open_r;
  logic [7:0]         target_r;
  logic [CNT_W-1:0]   count_r;
  logic signed [31:0] max_r;
  logic [IDX_W-1:0]   slot_r;
  logic               seen_r;
  logic               avail_r;

  logic               accept;
  logic [7:0]         target;
  logic               match;
  logic               store;
  logic [CNT_W-1:0]   count_nxt;
  logic signed [31:0] max_nxt;
  logic [IDX_W-1:0]   slot_nxt;
  logic               seen_nxt;
  logic               avail_nxt;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the incoming alternative against the set so far
  always_comb begin
    target    = open_r ? target_r : in_ch.chosen_key;
    match     = (in_ch.alt_key == target);
    store     = in_ch.available && (count_r < CNT_W'(MAX_ALTS));
    count_nxt = store ? count_r + 1'b1 : count_r;
    max_nxt   = (store && (in_ch.utility > max_r)) ? in_ch.utility : max_r;
    slot_nxt  = (store && match) ? count_r[IDX_W-1:0] : slot_r;
    seen_nxt  = match ? 1'b1 : seen_r;
    avail_nxt = match ? store : avail_r;
  end

  // Build the job for the back end on the closing transfer
  always_comb begin
    job.run      = seen_nxt && avail_nxt;
    job.log_mode = log_mode_r;
    job.max_u    = max_nxt;
    job.count    = JOB_CNT_W'(count_nxt);
    job.slot     = JOB_IDX_W'(slot_nxt);
    if (!seen_nxt)                    job.status = ST_ABSENT;
    else if (!avail_nxt && log_mode_r) job.status = ST_UNAVAIL;
    else                              job.status = ST_OK;
  end

  assign job_push  = accept && in_ch.last_alt;
  assign mem_we    = accept && store;
  assign mem_waddr = count_r[IDX_W-1:0];
  assign mem_wdata = in_ch.utility;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_mode_r <= 1'b1;
      busy_r     <= 1'b0;
      open_r     <= 1'b0;
      target_r   <= '0;
      count_r    <= '0;
      max_r      <= 32'sh8000_0000;
      slot_r     <= '0;
      seen_r     <= 1'b0;
      avail_r    <= 1'b0;
    end else begin
      if (cfg_we) log_mode_r <= cfg_wdata;
      if (set_done) busy_r <= 1'b0;
      if (accept) begin
        if (in_ch.last_alt) begin
          // Close the set: drop set state, hold input until the result is loaded for output
          busy_r   <= 1'b1;
          open_r   <= 1'b0;
          target_r <= '0;
          count_r  <= '0;
          max_r    <= 32'sh8000_0000;
          slot_r   <= '0;
          seen_r   <= 1'b0;
          avail_r  <= 1'b0;
        end else begin
          open_r   <= 1'b1;
          target_r <= target;
          count_r  <= count_nxt;
          max_r    <= max_nxt;
          slot_r   <= slot_nxt;
          seen_r   <= seen_nxt;
          avail_r  <= avail_nxt;
        end
      end
    end
  end
endmodule

// ===== hdl/mllp_back.sv =====
module mllp_back #(
  parameter int MAX_ALTS = mllp_pkg::MAX_ALTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        mem_we,
  input  logic [$clog2(MAX_ALTS)-1:0] mem_waddr,
  input  logic signed [31:0]          mem_wdata,
  input  logic                        job_empty,
  input  mllp_pkg::job_t              job,
  output logic                        job_pop,
  output logic                        set_done,
  mllp_out_if.source                  out_ch
);
  import mllp_pkg::*;

  localparam int IDX_W = $clog2(MAX_ALTS);
  localparam int CNT_W = $clog2(MAX_ALTS + 1);
  localparam int SW    = 31 + CNT_W;
  localparam int KW    = $clog2(SW);

  typedef enum logic [3:0] {
    B_IDLE, B_SHQ, B_SHM, B_RD, B_EXS, B_EXP, B_ACC, B_POST,
    B_NORM, B_LNDIV, B_LNSTEP, B_LNSUM, B_LNOUT, B_PDIV, B_DONE
  } state_t;

  state_t             state_r;
  job_t               job_r;
  logic signed [31:0] store_mem [MAX_ALTS];
  logic signed [31:0] rd_data_r;
  logic               neg_r;
  logic [15:0]        x_r;
  logic signed [33:0] shift_r;
  logic [IDX_W-1:0]   idx_r;
  logic [20:0]        mag_r;
  logic [30:0]        r_r;
  logic [4:0]         j_r;
  logic [SW-1:0]      sum_r;
  logic [30:0]        ec_r;
  logic signed [31:0] uc_r;
  logic [SW-1:0]      nrm_r;
  logic [KW-1:0]      k_r;
  logic [30:0]        t_r;
  logic [LN_BITS-1:0] n_r;
  logic signed [39:0] l30_r;
  logic signed [33:0] dc_r;
  logic signed [31:0] res_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;

  logic [61:0]          exp_prod;
  logic [30:0]          exp_rnd;
  logic signed [33:0]   mag_w;
  logic [32:0]          pos_v;
  logic [31:0]          neg_v;
  logic [32:0]          xq_prod;
  logic [13:0]          q;
  logic [16:0]          q10;
  logic [33:0]          shift_mag;
  logic signed [7:0]    km30;
  logic signed [38:0]   lprod;
  logic signed [39:0]   ln16;
  logic signed [39:0]   v40;
  logic                 out_free;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [SW-1:0]        div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // Utility store, one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= store_mem[idx_r];
  end

  // Datapath pieces used by the sequencer
  always_comb begin
    exp_prod  = 62'(r_r) * 62'(EXP_TAB[j_r]);
    exp_rnd   = 31'((exp_prod + 62'(HALF_Q30)) >> 30);
    mag_w     = shift_r - {{2{rd_data_r[31]}}, rd_data_r};
    pos_v     = {1'b0, job_r.max_u} + {1'b0, TEN_Q16_M1};
    neg_v     = ~job_r.max_u + 32'd1;
    xq_prod   = 33'(x_r) * 33'(RECIP10);
    q         = xq_prod[RECIP10_SH +: 14];
    q10       = {q, 3'b000} + {2'b00, q, 1'b0};
    shift_mag = {2'b00, q10[15:0], 16'h0000};
    km30      = $signed(8'(k_r) - 8'd30);
    lprod     = km30 * $signed({1'b0, LN2_Q30});
    ln16      = (l30_r + 40'sd8192) >>> 14;
    v40       = {{6{dc_r[33]}}, dc_r} - ln16;
    out_free  = !out_valid_r || out_ch.ready;
  end

  // Shared divider request: 2^60 / m for the log, scaled e_c / sum otherwise
  always_comb begin
    div_start = 1'b0;
    div_num   = (DIV_NUM_W)'(1) << 60;
    div_den   = SW'(nrm_r[SW-1 -: 31]);
    if (state_r == B_NORM && nrm_r[SW-1]) begin
      div_start = 1'b1;
    end else if (state_r == B_POST && !job_r.log_mode && sum_r != '0) begin
      div_start = 1'b1;
      div_num   = (DIV_NUM_W)'({ec_r, 16'h0000}) + (DIV_NUM_W)'(sum_r >> 1);
      div_den   = sum_r;
    end
  end

  mllp_div #(.NUM_W(DIV_NUM_W), .DEN_W(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign job_pop  = (state_r == B_IDLE) && !job_empty;
  assign set_done = (state_r == B_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !set_done) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!job_empty) begin
            job_r   <= job;
            res_r   <= '0;
            state_r <= job.run ? B_SHQ : B_DONE;
          end
        end
        // Shift = ceil(max / 10) * 10 in Q16, via the integer part over ten
        B_SHQ: begin
          neg_r   <= job_r.max_u[31];
          x_r     <= job_r.max_u[31] ? neg_v[31:16] : pos_v[31:16];
          state_r <= B_SHM;
        end
        B_SHM: begin
          shift_r <= neg_r ? -$signed(shift_mag) : $signed(shift_mag);
          idx_r   <= '0;
          sum_r   <= '0;
          state_r <= B_RD;
        end
        B_RD: state_r <= B_EXS;
        B_EXS: begin
          j_r <= '0;
          if (mag_w[33:21] != '0) begin
            r_r     <= '0;
            state_r <= B_ACC;
          end else begin
            mag_r   <= mag_w[20:0];
            r_r     <= ONE_Q30;
            state_r <= B_EXP;
          end
        end
        // One table factor per cycle for each bit of the magnitude
        B_EXP: begin
          if (mag_r[j_r]) r_r <= exp_rnd;
          if (j_r == 5'(EXP_TAB_N - 1)) state_r <= B_ACC;
          else j_r <= j_r + 1'b1;
        end
        B_ACC: begin
          sum_r <= sum_r + SW'(r_r);
          if (idx_r == job_r.slot[IDX_W-1:0]) begin
            ec_r <= r_r;
            uc_r <= rd_data_r;
          end
          if (CNT_W'(idx_r) + 1'b1 == job_r.count[CNT_W-1:0]) begin
            state_r <= B_POST;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= B_RD;
          end
        end
        B_POST: begin
          dc_r  <= {{2{uc_r[31]}}, uc_r} - shift_r;
          nrm_r <= (sum_r == '0) ? SW'(1) : sum_r;
          k_r   <= KW'(SW - 1);
          if (job_r.log_mode) state_r <= B_NORM;
          else if (sum_r == '0) begin
            res_r   <= 32'sh0000_FFFF;
            state_r <= B_DONE;
          end else state_r <= B_PDIV;
        end
        // Find the leading one, one position per cycle
        B_NORM: begin
          if (nrm_r[SW-1]) state_r <= B_LNDIV;
          else begin
            nrm_r <= nrm_r << 1;
            k_r   <= k_r - 1'b1;
          end
        end
        B_LNDIV: begin
          if (div_done) begin
            t_r     <= div_quo[30:0];
            r_r     <= ONE_Q30;
            n_r     <= '0;
            j_r     <= 5'(LN_BITS - 1);
            state_r <= B_LNSTEP;
          end
        end
        // Greedy ln bits: keep a bit while the product stays above 1/m
        B_LNSTEP: begin
          if (exp_rnd >= t_r) begin
            r_r           <= exp_rnd;
            n_r[j_r[3:0]] <= 1'b1;
          end
          if (j_r == '0) state_r <= B_LNSUM;
          else j_r <= j_r - 1'b1;
        end
        B_LNSUM: begin
          l30_r   <= 40'(lprod) + $signed({10'b0, n_r, 14'b0});
          state_r <= B_LNOUT;
        end
        B_LNOUT: begin
          if (v40 > 40'sd2147483647)       res_r <= 32'sh7FFF_FFFF;
          else if (v40 < -40'sd2147483648) res_r <= 32'sh8000_0000;
          else                             res_r <= v40[31:0];
          state_r <= B_DONE;
        end
        B_PDIV: begin
          if (div_done) begin
            res_r   <= (div_quo > (DIV_NUM_W)'(16'hFFFF)) ? 32'sh0000_FFFF
                                                          : {16'h0000, div_quo[15:0]};
            state_r <= B_DONE;
          end
        end
        // Load the output register once it is free
        B_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_r;
            out_status_r <= job_r.status;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;
endmodule

// ===== hdl/masked_logit_log_probability.sv =====
// Masked multinomial-logit log-probability unit.
// in_ch carries one alternative per transfer (key, Q16.16 utility, available,
// chosen key, last mark); the chosen key is taken from the first item of a set.
// out_ch carries one result per set (value, status) after the set's last item.
// cfg_we/cfg_wdata write log_mode (reset 1): 1 log-probability in Q16,
// 0 probability in Q0.16 in the low bits.
// Items before the last are accepted back to back. After the last transfer the
// input stalls while the back end works: an exp sweep over the N stored
// utilities (one shared multiplier, one table factor a cycle), then normalize,
// divide and ln bits in log mode, or a divide in probability mode. A set whose
// chosen key is missing or unavailable skips the sweep.
// Reset (rst_n low, synchronous) clears the set state and sets log_mode; the
// utility store needs no clearing. A finished result waits in the output
// register while out_ch.ready is low; the input stays stalled until it is
// loaded there.
`include "masked_logit_log_probability_defines.svh"

module masked_logit_log_probability #(
  parameter int MAX_ALTS = mllp_pkg::MAX_ALTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mllp_in_if.sink     in_ch,
  mllp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import mllp_pkg::*;

  localparam int IDX_W = $clog2(MAX_ALTS);

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               job_push;
  job_t               job_in;
  logic               job_pop;
  job_t               job_out;
  logic               job_empty;
  logic               set_done;

  mllp_front #(.MAX_ALTS(MAX_ALTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .set_done  (set_done),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  mllp_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  mllp_back #(.MAX_ALTS(MAX_ALTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .set_done  (set_done),
    .out_ch    (out_ch)
  );

  // Closing a set stalls the input
  `MLLP_ASSERT_NXT(a_stall_after_last, clk, rst_n,
                   in_ch.valid && in_ch.ready && in_ch.last_alt, !in_ch.ready,
                   "input not stalled after last item")
  // A result only appears while the input was stalled
  `MLLP_ASSERT_IMP(a_result_while_busy, clk, rst_n,
                   $rose(out_ch.valid), !$past(in_ch.ready),
                   "result without a closed set")
  // Error results carry a zero value
  `MLLP_ASSERT_IMP(a_error_zero, clk, rst_n,
                   out_ch.valid && (out_ch.status != ST_OK), out_ch.value == 0,
                   "error result with nonzero value")
endmodule

// ===== tb/masked_logit_log_probability_tb.sv =====
`timescale 1ns / 1ps

module masked_logit_log_probability_tb;
  import mllp_pkg::*;

  localparam int STORE_DEPTH = MAX_ALTS_DEF;
  localparam int IDLE_WAIT = 300;
  localparam int STALL_LIMIT = 40000;
  localparam longint TEN_Q16 = 655360;
  localparam longint LN2_Q30 = 744261118;

  typedef struct {
    logic [7:0]         key;
    logic signed [31:0] util;
    logic               avail;
    logic [7:0]         chosen;
    logic               last;
  } alt_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } choice_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  mllp_in_if in_if();
  mllp_out_if out_if();

  masked_logit_log_probability dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Pending alternatives and results still owed by the block
  alt_t pending_alts[$];
  choice_result_t owed_results[$];

  // Model copy of the set state and the mode register
  logic               mode_log = 1'b1;
  logic signed [31:0] util_store [STORE_DEPTH];
  int                 n_stored = 0;
  logic signed [31:0] max_util = 32'sh8000_0000;
  int                 chosen_idx = 0;
  logic               chosen_hit = 1'b0;
  logic               chosen_ok = 1'b0;
  logic [7:0]         target = 8'd0;
  logic               set_active = 1'b0;

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_status [3] = '{0, 0, 0};
  int n_prob = 0;

  // exp(-mag / 2^16) in Q30
  function automatic longint unsigned exp_q30(longint unsigned mag);
    longint unsigned r;
    r = 64'd1 << 30;
    if ((mag >> 21) != 0) return 0;
    for (int j = 0; j < 21; j++)
      if (mag[j]) r = (r * 64'(EXP_TAB[j]) + (64'd1 << 29)) >> 30;
    return r;
  endfunction

  // ln(s / 2^30) in Q16
  function automatic longint ln_q16(longint unsigned s);
    int k;
    longint unsigned m, t, r, cand;
    longint n, l30;
    k = 0;
    n = 0;
    r = 64'd1 << 30;
    if (s == 0) s = 1;
    for (int b = 0; b < 64; b++)
      if (s[b]) k = b;
    m = (k >= 30) ? (s >> (k - 30)) : (s << (30 - k));
    t = (64'd1 << 60) / m;
    for (int j = 15; j >= 0; j--) begin
      cand = (r * 64'(EXP_TAB[j]) + (64'd1 << 29)) >> 30;
      if (cand >= t) begin
        r = cand;
        n |= 64'sd1 << j;
      end
    end
    l30 = longint'(k - 30) * LN2_Q30 + n * 16384;
    return (l30 + 8192) >>> 14;
  endfunction

  // Absorb one alternative; on the last one, queue the set's result
  task automatic absorb_alt(alt_t a);
    logic hit, kept;
    longint mx, q, shift, dc, val;
    longint unsigned total, ec, p;
    choice_result_t res;
    kept = 1'b0;
    if (!set_active) begin
      target = a.chosen;
      set_active = 1'b1;
    end
    hit = (a.key == target);
    if (a.avail && n_stored < STORE_DEPTH) begin
      util_store[n_stored] = a.util;
      if (a.util > max_util) max_util = a.util;
      if (hit) chosen_idx = n_stored;
      n_stored++;
      kept = 1'b1;
    end
    if (hit) begin
      chosen_hit = 1'b1;
      chosen_ok = kept;
    end
    if (!a.last) return;
    res.value = '0;
    res.status = ST_OK;
    if (!chosen_hit) begin
      res.status = ST_ABSENT;
    end else if (!chosen_ok) begin
      res.status = mode_log ? ST_UNAVAIL : ST_OK;
    end else begin
      mx = longint'(max_util);
      q = (mx >= 0) ? (mx + TEN_Q16 - 1) / TEN_Q16 : -((-mx) / TEN_Q16);
      shift = q * TEN_Q16;
      total = 0;
      for (int i = 0; i < n_stored; i++)
        total += exp_q30(longint'(shift - longint'(util_store[i])));
      dc = longint'(util_store[chosen_idx]) - shift;
      if (mode_log) begin
        val = dc - ln_q16(total);
        if (val > 64'sd2147483647) val = 64'sd2147483647;
        if (val < -64'sd2147483648) val = -64'sd2147483648;
        res.value = val[31:0];
      end else begin
        ec = exp_q30(longint'(-dc));
        if (total == 0) begin
          p = 16'hFFFF;
        end else begin
          p = ((ec << 16) + total / 2) / total;
          if (p > 64'hFFFF) p = 64'hFFFF;
        end
        res.value = p[31:0];
      end
    end
    owed_results.insert(owed_results.size(), res);
    n_stored = 0;
    max_util = 32'sh8000_0000;
    chosen_idx = 0;
    chosen_hit = 1'b0;
    chosen_ok = 1'b0;
    target = 8'd0;
    set_active = 1'b0;
  endtask

  function automatic alt_t mk_alt(int key, logic [31:0] u, int av, int ck, int lst);
    alt_t a;
    a.key = key[7:0];
    a.util = u;
    a.avail = av[0];
    a.chosen = ck[7:0];
    a.last = lst[0];
    return a;
  endfunction

  // Add one alternative at the tail of the pending queue
  function automatic void append_alt(alt_t a);
    pending_alts.insert(pending_alts.size(), a);
  endfunction

  // Directed sets: extremes, absent and unavailable chosen, duplicate keys
  task automatic queue_directed();
    append_alt(mk_alt(5, 32'd0, 1, 5, 1));
    append_alt(mk_alt(1, 32'h0001_0000, 1, 9, 0));
    append_alt(mk_alt(2, 32'hFFFF_0000, 1, 0, 1));
    append_alt(mk_alt(3, 32'h0002_0000, 0, 3, 0));
    append_alt(mk_alt(4, 32'h0003_0000, 1, 0, 1));
    append_alt(mk_alt(7, 32'h0000_0064, 1, 7, 0));
    append_alt(mk_alt(7, 32'h0005_0000, 0, 0, 1));
    append_alt(mk_alt(7, 32'h0005_0000, 0, 7, 0));
    append_alt(mk_alt(7, 32'h0000_0064, 1, 0, 0));
    append_alt(mk_alt(8, 32'h0001_8000, 1, 0, 1));
    append_alt(mk_alt(0, 32'h7FFF_FFFF, 1, 255, 0));
    append_alt(mk_alt(255, 32'h8000_0000, 1, 0, 1));
    append_alt(mk_alt(255, 32'h8000_0000, 1, 255, 0));
    append_alt(mk_alt(0, 32'h8000_0001, 1, 0, 1));
    append_alt(mk_alt(170, 32'h7FFF_FFFF, 1, 85, 0));
    append_alt(mk_alt(85, 32'h7FF0_0000, 1, 0, 1));
    append_alt(mk_alt(9, 32'h0000_1234, 0, 9, 0));
    append_alt(mk_alt(10, 32'h0000_1234, 0, 0, 1));
    append_alt(mk_alt(11, 32'hFFF6_0000, 1, 12, 0));
    append_alt(mk_alt(12, 32'hFFEC_0001, 1, 0, 0));
    append_alt(mk_alt(13, 32'hFFD0_0000, 1, 0, 1));
  endtask

  // One random choice set; returns the number of alternatives queued
  function automatic int queue_random_set();
    int n, kspan, pick, ck;
    logic signed [31:0] base;
    logic [31:0] u;
    int umode;
    alt_t a;
    n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    kspan = ($urandom_range(0, 2) == 0) ? 255 : 15;
    pick = $urandom_range(0, n - 1);
    ck = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : -1;
    base = $urandom_range(0, 1) ? $signed($urandom()) >>> $urandom_range(0, 8)
                                : $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    umode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      a.key = 8'($urandom_range(0, kspan));
      if (umode == 0) u = $urandom();
      else u = base + $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      a.util = u;
      a.avail = ($urandom_range(0, 6) != 0);
      a.chosen = 8'($urandom_range(0, 255));
      a.last = (i == n - 1);
      if (i == pick && ck < 0) ck = a.key;
      append_alt(a);
    end
    // the chosen key rides on the set's first alternative
    pending_alts[pending_alts.size() - n].chosen = (ck < 0) ? 8'd0 : ck[7:0];
    return n;
  endfunction

  // Sender: bursts of random length with random gaps
  logic in_acc = 1'b0;
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk) begin
    logic nv;
    alt_t a;
    nv = 1'b0;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (in_if.valid && !in_acc) begin
      nv = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_alts.size() > 0) begin
      a = pending_alts.pop_front();
      in_if.alt_key <= a.key;
      in_if.utility <= a.util;
      in_if.available <= a.avail;
      in_if.chosen_key <= a.chosen;
      in_if.last_alt <= a.last;
      nv = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    in_if.valid <= nv;
  end

  // Receiver: stall pattern that switches among four random modes
  int rdy_cycle = 0;
  int rdy_mode = 0;
  always @(negedge clk) begin
    logic nr;
    rdy_cycle++;
    if (rdy_cycle % 100 == 0) rdy_mode = $urandom_range(0, 3);
    case (rdy_mode)
      0: nr = 1'b1;
      1: nr = ($urandom_range(0, 3) != 0);
      2: nr = ($urandom_range(0, 3) == 0);
      default: nr = rdy_cycle[3];
    endcase
    out_if.ready <= nr;
  end

  // Predict on each input transfer, check each result transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    alt_t a;
    choice_result_t exp_res;
    if (rst_n) begin
      in_acc <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        a.key = in_if.alt_key;
        a.util = in_if.utility;
        a.avail = in_if.available;
        a.chosen = in_if.chosen_key;
        a.last = in_if.last_alt;
        n_items++;
        absorb_alt(a);
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: value %h status %0d",
                   $time, out_if.value, out_if.status);
        end else begin
          exp_res = owed_results.pop_front();
          if (out_if.status < 3) n_status[out_if.status]++;
          if (out_if.value !== exp_res.value) begin
            errors++;
            $display("%0t: value mismatch: expected %h actual %h",
                     $time, exp_res.value, out_if.value);
          end
          if (out_if.status !== exp_res.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_res.status, out_if.status);
          end
        end
      end
      // watchdog on cycles with nothing moving while work is outstanding
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (pending_alts.size() == 0 && !in_if.valid && owed_results.size() == 0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("masked_logit_log_probability_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_mode(logic m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_log = m;
    if (!m) n_prob++;
  endtask

  task automatic drain();
    wait (pending_alts.size() == 0 && !in_if.valid && owed_results.size() == 0);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  initial begin
    int target_items;
    in_if.valid = 1'b0;
    in_if.alt_key = '0;
    in_if.utility = '0;
    in_if.available = 1'b0;
    in_if.chosen_key = '0;
    in_if.last_alt = 1'b0;
    out_if.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // log mode from reset, then probability, then both written explicitly
    queue_directed();
    drain();
    write_mode(1'b0);
    queue_directed();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ? 1'b0 : 1'b1);
      target_items = 0;
      while (target_items < 380) target_items += queue_random_set();
      drain();
    end

    $display("covered %0d alternatives, %0d choice sets (ok %0d, absent %0d, unavailable %0d)",
             n_items, n_results, n_status[0], n_status[1], n_status[2]);
    $display("both output modes, with %0d switches into probability mode", n_prob);
    if (errors == 0) begin
      $display("masked_logit_log_probability_tb: done, clean");
    end else begin
      $display("masked_logit_log_probability_tb: done, errors");
    end
    $finish;
  end

endmodule
